/* rtl/dlt_pkg.sv */
// dlt_pkg: shared types, constants and register map of the DShot line transceiver.
// No dependencies; used by every module in rtl/.
package dlt_pkg;

    localparam int FRAME_BITS = 16;
    localparam int BIT_IDX_W  = $clog2(FRAME_BITS + 2);
    localparam int WORD_W     = 16;
    localparam int PERIOD_W   = 10;
    localparam int HIGH_W     = 10;
    localparam int TOL_W      = 8;
    localparam int HCOUNT_W   = PERIOD_W + 1;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_BIT_PERIOD = 2'd0;
    localparam logic [1:0] REG_ZERO_HIGH  = 2'd1;
    localparam logic [1:0] REG_ONE_HIGH   = 2'd2;
    localparam logic [1:0] REG_TOLERANCE  = 2'd3;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = 10'd161;
    localparam logic [HIGH_W-1:0]   ZERO_HIGH_RST  = 10'd56;
    localparam logic [HIGH_W-1:0]   ONE_HIGH_RST   = 10'd112;
    localparam logic [TOL_W-1:0]    TOLERANCE_RST  = 8'd5;

    typedef struct packed {
        logic [PERIOD_W-1:0] bit_period;
        logic [HIGH_W-1:0]   zero_high;
        logic [HIGH_W-1:0]   one_high;
        logic [TOL_W-1:0]    tolerance;
    } t_cfg;

    typedef struct packed {
        logic              req_type;
        logic [WORD_W-1:0] send_word;
        logic              line_in;
    } t_tick;

    typedef struct packed {
        logic              line_out;
        logic              drive_enable;
        logic              tx_busy;
        logic              rx_valid;
        logic [WORD_W-1:0] rx_word;
    } t_result;

endpackage

/* rtl/dshot_line_transceiver_top.sv */
// dshot_line_transceiver_top: input beat register, core step, result register.
// Throughput: 1 beat per cycle while m_tready is held high, set by the state update
// in dlt_core, taken once per beat; a stalled result register
// still lets one more input beat be held in the input register.
// Reset (synchronous, active low) clears both beat valid flags, the line state and
// the timing registers to their defaults. Depends on dlt_pkg, dlt_cfg, dlt_core.
module dshot_line_transceiver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] send_word, [16] line_in, [23:17] zero
    input  logic [0:0]  s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] line_out, [1] drive_enable, [2] tx_busy,
                                   // [18:3] rx_word, [23:19] zero
    output logic [0:0]  m_tuser,   // [0] rx_valid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dlt_pkg::t_cfg    w_cfg;
    dlt_pkg::t_result w_result;
    dlt_pkg::t_tick   r_in;
    dlt_pkg::t_result r_out;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             w_adv;
    logic             w_in_fire;

    dlt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dlt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_adv),
        .i_tick   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    assign w_adv     = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready  = !r_in_valid || w_adv;
    assign w_in_fire = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in.req_type  <= s_tuser[0];
            r_in.send_word <= s_tdata[15:0];
            r_in.line_in   <= s_tdata[16];
        end
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {5'd0, r_out.rx_word, r_out.tx_busy, r_out.drive_enable,
                       r_out.line_out};
    assign m_tuser  = r_out.rx_valid;

    // line is driven and busy flagged together
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[1] == m_tdata[2]))
        else $error("drive_enable and tx_busy disagree");

    // a high level is only output while driving
    a_line_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[0]) |-> m_tdata[1])
        else $error("line_out high while released");

    // no word is received while transmitting
    a_rx_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0]) |-> !m_tdata[1])
        else $error("rx_valid while driving");

    // rx_word is zero when no word completes
    a_rx_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[18:3] == 16'd0))
        else $error("rx_word nonzero without rx_valid");

endmodule

/* rtl/dlt_cfg.sv */
// dlt_cfg: APB register file holding bit timing and receive window settings.
// Depends on dlt_pkg.
module dlt_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output dlt_pkg::t_cfg      o_cfg
);

    dlt_pkg::t_cfg r_cfg;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_period <= dlt_pkg::BIT_PERIOD_RST;
            r_cfg.zero_high  <= dlt_pkg::ZERO_HIGH_RST;
            r_cfg.one_high   <= dlt_pkg::ONE_HIGH_RST;
            r_cfg.tolerance  <= dlt_pkg::TOLERANCE_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                dlt_pkg::REG_BIT_PERIOD: r_cfg.bit_period <= pwdata[dlt_pkg::PERIOD_W-1:0];
                dlt_pkg::REG_ZERO_HIGH:  r_cfg.zero_high  <= pwdata[dlt_pkg::HIGH_W-1:0];
                dlt_pkg::REG_ONE_HIGH:   r_cfg.one_high   <= pwdata[dlt_pkg::HIGH_W-1:0];
                dlt_pkg::REG_TOLERANCE:  r_cfg.tolerance  <= pwdata[dlt_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            dlt_pkg::REG_BIT_PERIOD: prdata = {22'd0, r_cfg.bit_period};
            dlt_pkg::REG_ZERO_HIGH:  prdata = {22'd0, r_cfg.zero_high};
            dlt_pkg::REG_ONE_HIGH:   prdata = {22'd0, r_cfg.one_high};
            dlt_pkg::REG_TOLERANCE:  prdata = {24'd0, r_cfg.tolerance};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

/* rtl/dlt_core.sv */
// dlt_core: transmit/receive state machine, advanced once per accepted tick.
// Depends on dlt_pkg. Result is combinational; the top level registers it.
module dlt_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  dlt_pkg::t_tick    i_tick,
    input  dlt_pkg::t_cfg     i_cfg,
    output dlt_pkg::t_result  o_result
);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TX   = 2'd1,
        MODE_RX   = 2'd2
    } t_mode;

    t_mode                            r_mode, n_mode;
    logic [dlt_pkg::PERIOD_W-1:0]     r_slot, n_slot;
    logic [dlt_pkg::BIT_IDX_W-1:0]    r_bit, n_bit;
    logic [dlt_pkg::WORD_W-1:0]       r_tx_shift, n_tx_shift;
    logic [dlt_pkg::HCOUNT_W-1:0]     r_high, n_high;
    logic                             r_prev, n_prev;
    logic [dlt_pkg::WORD_W-1:0]       r_rx_shift, n_rx_shift;
    logic [dlt_pkg::BIT_IDX_W-1:0]    r_rx_count, n_rx_count;

    always_comb begin
        logic [dlt_pkg::HCOUNT_W-1:0]   cap;
        logic                           pulse_one;
        logic [dlt_pkg::WORD_W-1:0]     shifted;
        logic [dlt_pkg::BIT_IDX_W-1:0]  cnt;
        logic [dlt_pkg::BIT_IDX_W-1:0]  pos;
        logic                           tx_bit;
        logic [dlt_pkg::HIGH_W-1:0]     hi_ticks;
        logic [dlt_pkg::BIT_IDX_W-1:0]  nb;

        n_mode     = r_mode;
        n_slot     = r_slot;
        n_bit      = r_bit;
        n_tx_shift = r_tx_shift;
        n_high     = r_high;
        n_prev     = r_prev;
        n_rx_shift = r_rx_shift;
        n_rx_count = r_rx_count;
        o_result   = '0;

        cap = {i_cfg.bit_period, 1'b0};
        // lo < len < hi, with lo possibly negative: len + tol > one_high
        pulse_one = (({1'b0, r_high} + 12'(i_cfg.tolerance)) > 12'(i_cfg.one_high))
                 && ({1'b0, r_high} < (12'(i_cfg.one_high) + 12'(i_cfg.tolerance)));
        shifted = {r_rx_shift[dlt_pkg::WORD_W-2:0], pulse_one};
        cnt     = r_rx_count + 1'b1;

        if (i_tick.req_type && r_mode != MODE_TX) begin
            n_mode     = MODE_TX;
            n_tx_shift = i_tick.send_word;
            n_slot     = '0;
            n_bit      = '0;
            n_rx_shift = '0;
            n_rx_count = '0;
            n_high     = '0;
            n_prev     = 1'b0;
        end else if (r_mode == MODE_RX) begin
            if (i_tick.line_in) begin
                if (r_high < cap) begin
                    n_high = r_high + 1'b1;
                end
            end else if (r_prev) begin
                // falling edge: decode the pulse just ended
                if (cnt >= dlt_pkg::BIT_IDX_W'(dlt_pkg::FRAME_BITS)) begin
                    o_result.rx_valid = 1'b1;
                    o_result.rx_word  = shifted;
                    n_rx_count = '0;
                    n_rx_shift = '0;
                end else begin
                    n_rx_count = cnt;
                    n_rx_shift = shifted;
                end
                n_high = '0;
            end else begin
                n_high = '0;
            end
            n_prev = i_tick.line_in;
        end

        pos = dlt_pkg::BIT_IDX_W'(dlt_pkg::FRAME_BITS - 1) - n_bit;
        tx_bit = (pos > dlt_pkg::BIT_IDX_W'(dlt_pkg::WORD_W - 1)) ? 1'b0
               : n_tx_shift[pos[$clog2(dlt_pkg::WORD_W)-1:0]];
        hi_ticks = tx_bit ? i_cfg.one_high : i_cfg.zero_high;
        nb = n_bit + 1'b1;

        if (n_mode == MODE_TX) begin
            o_result.drive_enable = 1'b1;
            o_result.tx_busy      = 1'b1;
            if (n_bit < dlt_pkg::BIT_IDX_W'(dlt_pkg::FRAME_BITS)) begin
                o_result.line_out = (n_slot < hi_ticks);
            end
            if (({1'b0, n_slot} + 1'b1) >= {1'b0, i_cfg.bit_period}) begin
                n_slot = '0;
                if (nb > dlt_pkg::BIT_IDX_W'(dlt_pkg::FRAME_BITS)) begin
                    // trailing low slot done: release line, arm receive
                    n_mode     = MODE_RX;
                    n_bit      = '0;
                    n_high     = '0;
                    n_prev     = 1'b0;
                    n_rx_shift = '0;
                    n_rx_count = '0;
                end else begin
                    n_bit = nb;
                end
            end else begin
                n_slot = n_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_slot     <= '0;
            r_bit      <= '0;
            r_tx_shift <= '0;
            r_high     <= '0;
            r_prev     <= 1'b0;
            r_rx_shift <= '0;
            r_rx_count <= '0;
        end else if (i_step) begin
            r_mode     <= n_mode;
            r_slot     <= n_slot;
            r_bit      <= n_bit;
            r_tx_shift <= n_tx_shift;
            r_high     <= n_high;
            r_prev     <= n_prev;
            r_rx_shift <= n_rx_shift;
            r_rx_count <= n_rx_count;
        end
    end

endmodule

/* dv/tb.sv */
// tb: self-checking bench for dshot_line_transceiver_top. Per-tick line model in a small
// scoreboard, stream beats with random gaps and stalls, APB register phases.
// Depends on dlt_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module tb;

    typedef enum logic [1:0] {
        LINE_IDLE = 2'd0,
        LINE_TX   = 2'd1,
        LINE_RX   = 2'd2
    } t_line_mode;

    class line_scoreboard;
        dlt_pkg::t_cfg                 cfg;
        t_line_mode                    mode;
        logic [dlt_pkg::PERIOD_W-1:0]  slot_tick;
        logic [dlt_pkg::BIT_IDX_W-1:0] bit_index;
        logic [dlt_pkg::WORD_W-1:0]    tx_shift;
        logic [dlt_pkg::HCOUNT_W-1:0]  high_count;
        logic                          prev_level;
        logic [dlt_pkg::WORD_W-1:0]    rx_shift;
        logic [dlt_pkg::BIT_IDX_W-1:0] rx_count;
        dlt_pkg::t_result              expected_beats[$];
        int                            n_errors;

        function new();
            cfg = '{dlt_pkg::BIT_PERIOD_RST, dlt_pkg::ZERO_HIGH_RST, dlt_pkg::ONE_HIGH_RST,
                    dlt_pkg::TOLERANCE_RST};
            mode = LINE_IDLE;
            slot_tick = '0;
            bit_index = '0;
            tx_shift = '0;
            high_count = '0;
            prev_level = 1'b0;
            rx_shift = '0;
            rx_count = '0;
            n_errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                dlt_pkg::REG_BIT_PERIOD: cfg.bit_period = val[dlt_pkg::PERIOD_W-1:0];
                dlt_pkg::REG_ZERO_HIGH:  cfg.zero_high  = val[dlt_pkg::HIGH_W-1:0];
                dlt_pkg::REG_ONE_HIGH:   cfg.one_high   = val[dlt_pkg::HIGH_W-1:0];
                default:                 cfg.tolerance  = val[dlt_pkg::TOL_W-1:0];
            endcase
        endfunction

        function logic [31:0] reg_value(logic [1:0] idx);
            case (idx)
                dlt_pkg::REG_BIT_PERIOD: return 32'(cfg.bit_period);
                dlt_pkg::REG_ZERO_HIGH:  return 32'(cfg.zero_high);
                dlt_pkg::REG_ONE_HIGH:   return 32'(cfg.one_high);
                default:                 return 32'(cfg.tolerance);
            endcase
        endfunction

        function void flag(string what);
            n_errors++;
            if (n_errors <= 10)
                $display("mismatch: %s", what);
        endfunction

        // one accepted tick -> the line state it produces
        function void note_tick(dlt_pkg::t_tick t);
            dlt_pkg::t_result             r;
            int                           lo;
            int                           hi;
            logic [dlt_pkg::HIGH_W-1:0]   high_ticks;
            r = '0;
            if (t.req_type && mode != LINE_TX) begin
                // new frame; any partial receive is dropped
                mode = LINE_TX;
                tx_shift = t.send_word;
                slot_tick = '0;
                bit_index = '0;
                rx_shift = '0;
                rx_count = '0;
                high_count = '0;
                prev_level = 1'b0;
            end else if (mode == LINE_RX) begin
                if (t.line_in) begin
                    if (int'(high_count) < 2 * int'(cfg.bit_period))
                        high_count++;
                end else if (prev_level) begin
                    lo = int'(cfg.one_high) - int'(cfg.tolerance);
                    hi = int'(cfg.one_high) + int'(cfg.tolerance);
                    rx_shift = {rx_shift[dlt_pkg::WORD_W-2:0],
                                (int'(high_count) > lo && int'(high_count) < hi)};
                    rx_count++;
                    if (int'(rx_count) >= dlt_pkg::FRAME_BITS) begin
                        r.rx_valid = 1'b1;
                        r.rx_word = rx_shift;
                        rx_count = '0;
                        rx_shift = '0;
                    end
                    high_count = '0;
                end else begin
                    high_count = '0;
                end
                prev_level = t.line_in;
            end

            if (mode == LINE_TX) begin
                r.drive_enable = 1'b1;
                r.tx_busy = 1'b1;
                if (int'(bit_index) < dlt_pkg::FRAME_BITS) begin
                    high_ticks = tx_shift[dlt_pkg::FRAME_BITS-1-int'(bit_index)]
                               ? cfg.one_high : cfg.zero_high;
                    r.line_out = (slot_tick < high_ticks);
                end
                if (int'(slot_tick) + 1 >= int'(cfg.bit_period)) begin
                    slot_tick = '0;
                    bit_index++;
                    // trailing low slot done: release the line, arm receive
                    if (int'(bit_index) > dlt_pkg::FRAME_BITS) begin
                        mode = LINE_RX;
                        bit_index = '0;
                        high_count = '0;
                        prev_level = 1'b0;
                        rx_shift = '0;
                        rx_count = '0;
                    end
                end else begin
                    slot_tick++;
                end
            end
            expected_beats.push_back(r);
        endfunction

        function void check_beat(dlt_pkg::t_result got);
            dlt_pkg::t_result want;
            if (expected_beats.size() == 0) begin
                flag($sformatf("result beat with nothing pending: %h", got));
                return;
            end
            want = expected_beats.pop_front();
            if (got.line_out !== want.line_out || got.drive_enable !== want.drive_enable ||
                got.tx_busy !== want.tx_busy || got.rx_valid !== want.rx_valid ||
                got.rx_word !== want.rx_word)
                flag($sformatf({"exp line %b drv %b busy %b valid %b word %h, ",
                                "got line %b drv %b busy %b valid %b word %h"},
                               want.line_out, want.drive_enable, want.tx_busy,
                               want.rx_valid, want.rx_word, got.line_out,
                               got.drive_enable, got.tx_busy, got.rx_valid, got.rx_word));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [15:0] send_word, [16] line_in, [23:17] zero
    logic [0:0]  s_tuser;   // [0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [0] line_out, [1] drive_enable, [2] tx_busy, [18:3] rx_word
    logic [0:0]  m_tuser;   // [0] rx_valid
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    line_scoreboard sb;
    int             snd_idle;
    int             rcv_stall;
    int             n_sent;

    dshot_line_transceiver_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 i_clk = ~i_clk;

    // result side: check the beat taken at this edge, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_beat('{line_out: m_tdata[0], drive_enable: m_tdata[1],
                            tx_busy: m_tdata[2], rx_valid: m_tuser[0],
                            rx_word: m_tdata[18:3]});
        m_tready <= ($urandom_range(0, 99) >= rcv_stall);
    end

    task automatic drive_tick(input logic req, input logic [dlt_pkg::WORD_W-1:0] word,
                              input logic lvl);
        dlt_pkg::t_tick t;
        t.req_type = req;
        t.send_word = word;
        t.line_in = lvl;
        if ($urandom_range(0, 99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < snd_idle)
                @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, lvl, word};
        s_tuser <= req;
        do @(posedge i_clk); while (!s_tready);
        sb.note_tick(t);
        n_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_beats.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_read(input logic [1:0] idx);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== sb.reg_value(idx))
            sb.flag($sformatf("reg %0d read exp %h got %h", idx, sb.reg_value(idx), prdata));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_regs();
        reg_read(dlt_pkg::REG_BIT_PERIOD);
        reg_read(dlt_pkg::REG_ZERO_HIGH);
        reg_read(dlt_pkg::REG_ONE_HIGH);
        reg_read(dlt_pkg::REG_TOLERANCE);
    endtask

    // high time of one received pulse: window edges, nominal widths, random up to
    // a little past the saturation point
    function automatic int pulse_len(dlt_pkg::t_cfg c);
        int cap;
        int lo;
        int hi;
        int v;
        cap = 2 * int'(c.bit_period) + 2;
        lo = int'(c.one_high) - int'(c.tolerance);
        hi = int'(c.one_high) + int'(c.tolerance);
        case ($urandom_range(0, 7))
            0: v = lo;
            1: v = lo + 1;
            2: v = hi - 1;
            3: v = hi;
            4: v = int'(c.zero_high);
            5: v = int'(c.one_high);
            default: v = $urandom_range(1, cap);
        endcase
        if (v > cap)
            v = cap;
        if (v < 1)
            v = 1;
        return v;
    endfunction

    task automatic run_phase(input int bp, input int zh, input int oh, input int tol,
                             input int snd, input int rcv, input int budget,
                             input logic [dlt_pkg::WORD_W-1:0] lead_word);
        int  start;
        int  pick;
        bit  paused;
        drain();
        repeat (4) @(posedge i_clk);
        reg_write(dlt_pkg::REG_BIT_PERIOD, bp);
        reg_write(dlt_pkg::REG_ZERO_HIGH, zh);
        reg_write(dlt_pkg::REG_ONE_HIGH, oh);
        reg_write(dlt_pkg::REG_TOLERANCE, tol);
        check_regs();
        snd_idle = snd;
        rcv_stall = rcv;
        start = n_sent;
        paused = 1'b0;
        if (sb.mode != LINE_TX)
            drive_tick(1'b1, lead_word, 1'b1);
        while (n_sent - start < budget) begin
            if (!paused && n_sent - start >= budget / 2) begin
                // hold the input until the pipeline is empty
                paused = 1'b1;
                drain();
            end
            if (sb.mode == LINE_TX) begin
                // a request here must be ignored
                drive_tick($urandom_range(0, 99) < 3, 16'($urandom),
                           1'($urandom_range(0, 1)));
            end else if (sb.mode == LINE_IDLE) begin
                drive_tick(1'b1, 16'($urandom), 1'($urandom_range(0, 1)));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    drive_tick(1'b1, 16'($urandom), 1'($urandom_range(0, 1)));
                end else if (pick < 10) begin
                    drive_tick(1'b0, 16'($urandom), 1'($urandom_range(0, 1)));
                end else begin
                    repeat (pulse_len(sb.cfg)) drive_tick(1'b0, 16'($urandom), 1'b1);
                    repeat ($urandom_range(1, 3)) drive_tick(1'b0, 16'($urandom), 1'b0);
                end
            end
        end
    endtask

    initial begin
        sb = new();
        snd_idle = 0;
        rcv_stall = 0;
        n_sent = 0;
        i_rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        m_tready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_regs();

        // no frame sent yet: line pulses must not decode
        drive_tick(1'b0, 16'hFFFF, 1'b1);
        drive_tick(1'b0, 16'h0000, 1'b1);
        drive_tick(1'b0, 16'hFFFF, 1'b0);
        repeat (8) drive_tick(1'b0, 16'($urandom), 1'($urandom_range(0, 1)));

        run_phase(1, 0, 1, 1, 0, 0, 100, 16'hFFFF);
        run_phase(0, 1, 1, 1, 9, 9, 80, 16'h0000);
        run_phase(4, 1, 3, 1, 88, 0, 300, 16'($urandom));
        run_phase(3, 1023, 0, 5, 0, 88, 250, 16'($urandom));
        run_phase(6, 2, 4, 255, 9, 9, 250, 16'($urandom));
        run_phase(5, 2, 4, 1, 0, 0, 300, 16'($urandom));

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.n_errors == 0 && sb.expected_beats.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("tb: errors");
        $finish;
    end

endmodule
